@@ rtl/bmh_pkg.sv @@
`default_nettype none
package bmh_pkg;

    localparam int AVG_DEPTH = 8;                  // power of two
    localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;
    localparam int CODE_W    = 12;
    localparam int CMP_W     = 18;
    localparam int VOLT_HYST = 200;
    localparam int CURR_HYST = 500;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        CFG_VOLTAGE_GAIN    = 4'd0,
        CFG_CURRENT_OFFSET  = 4'd1,
        CFG_CURRENT_GAIN    = 4'd2,
        CFG_MIN_BATTERY     = 4'd3,
        CFG_LOW_BATTERY     = 4'd4,
        CFG_BATTERY_PRESENT = 4'd5,
        CFG_OVERVOLT        = 4'd6,
        CFG_OVERCURRENT     = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] voltage_gain;
        logic [11:0] current_offset;
        logic [15:0] current_gain;
        logic [15:0] min_battery_level;
        logic [15:0] low_battery_level;
        logic [15:0] battery_present_level;
        logic [15:0] overvolt_level;
        logic [14:0] overcurrent_level;
    } bmh_cfg_t;

    typedef struct packed {
        op_t                     op;
        logic [SUM_W-1:0]        vsum;
        logic signed [SUM_W-1:0] csum;
    } bmh_sum_item_t;

    typedef struct packed {
        logic [15:0]        avg_voltage;
        logic signed [15:0] avg_current;
        logic               on_external;
        logic               battery_low;
        logic               overvolt_error;
        logic               overcurrent_error;
        logic               min_battery_error;
        logic               any_error;
    } bmh_result_t;

endpackage
`default_nettype wire

@@ rtl/battery_monitor_hysteresis.sv @@
`default_nettype none
// Battery monitor: takes one word per clock while the output is not stalled and returns
// one result word for each, through the scaling, window-sum and comparator registers;
// the window sum is updated behind the eight-cell window shift line, and the comparator
// stage follows it. Input tuser is the opcode (0 sample, 1 clear
// error latches). The window and all comparator state clear at reset. Configuration
// writes take effect at once and belong in idle periods; indexes beyond 7 are ignored.
module battery_monitor_hysteresis
    import bmh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [11:0] voltage_code, [23:12] current_code
    input  wire logic [23:0] s_axis_tdata,
    // [0] opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] avg_voltage, [31:16] avg_current, [32] on_external, [33] battery_low,
    // [34] overvolt_error, [35] overcurrent_error, [36] min_battery_error,
    // [37] any_error, [39:38] zero
    output logic [39:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    bmh_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_gain          <= 16'd256;
            cfg_reg.current_offset        <= 12'd2048;
            cfg_reg.current_gain          <= 16'd256;
            cfg_reg.min_battery_level     <= 16'd3300;
            cfg_reg.low_battery_level     <= 16'd3500;
            cfg_reg.battery_present_level <= 16'd1000;
            cfg_reg.overvolt_level        <= 16'd4300;
            cfg_reg.overcurrent_level     <= 15'd10000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VOLTAGE_GAIN:    cfg_reg.voltage_gain          <= cfg_data;
                CFG_CURRENT_OFFSET:  cfg_reg.current_offset        <= cfg_data[11:0];
                CFG_CURRENT_GAIN:    cfg_reg.current_gain          <= cfg_data;
                CFG_MIN_BATTERY:     cfg_reg.min_battery_level     <= cfg_data;
                CFG_LOW_BATTERY:     cfg_reg.low_battery_level     <= cfg_data;
                CFG_BATTERY_PRESENT: cfg_reg.battery_present_level <= cfg_data;
                CFG_OVERVOLT:        cfg_reg.overvolt_level        <= cfg_data;
                CFG_OVERCURRENT:     cfg_reg.overcurrent_level     <= cfg_data[14:0];
                default:             ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, out_valid_reg;
    logic ready1, ready2, ready3;
    logic load2, load3;

    assign ready3        = !out_valid_reg || m_axis_tready;
    assign ready2        = !v2_reg || ready3;
    assign ready1        = !v1_reg || ready2;
    assign s_axis_tready = ready1;
    assign load2         = v1_reg && ready2;
    assign load3         = v2_reg && ready3;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= s_axis_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                out_valid_reg <= v2_reg;
        end
    end

    // stage 1: scaling
    logic [SAMPLE_W-1:0]        volt_scaled;
    logic signed [SAMPLE_W-1:0] curr_scaled;
    op_t                        op1_reg;
    logic [SAMPLE_W-1:0]        volt1_reg;
    logic signed [SAMPLE_W-1:0] curr1_reg;

    bmh_scale u_scale (
        .cfg          (cfg_reg),
        .voltage_code (s_axis_tdata[11:0]),
        .current_code (s_axis_tdata[23:12]),
        .volt_scaled  (volt_scaled),
        .curr_scaled  (curr_scaled)
    );

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            op1_reg   <= op_t'(s_axis_tuser);
            volt1_reg <= volt_scaled;
            curr1_reg <= curr_scaled;
        end
    end

    // stage 2: window shift line and running sums
    logic                       shift;
    logic [SAMPLE_W-1:0]        chain_volt [AVG_DEPTH+1];
    logic signed [SAMPLE_W-1:0] chain_curr [AVG_DEPTH+1];
    logic [SUM_W-1:0]           vsum_reg, vsum_next;
    logic signed [SUM_W-1:0]    csum_reg, csum_next;
    bmh_sum_item_t              item2_reg;

    assign shift         = load2 && op1_reg == OP_SAMPLE;
    assign chain_volt[0] = volt1_reg;
    assign chain_curr[0] = curr1_reg;

    for (genvar i = 0; i < AVG_DEPTH; i++)
    begin : g_cell
        bmh_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .volt_in  (chain_volt[i]),
            .curr_in  (chain_curr[i]),
            .volt_out (chain_volt[i+1]),
            .curr_out (chain_curr[i+1])
        );
    end

    always_comb
    begin
        vsum_next = vsum_reg;
        csum_next = csum_reg;
        if (op1_reg == OP_SAMPLE)
        begin
            // add the newest entry, drop the oldest at the end of the line
            vsum_next = vsum_reg + SUM_W'(volt1_reg) - SUM_W'(chain_volt[AVG_DEPTH]);
            csum_next = csum_reg + SUM_W'(curr1_reg) - SUM_W'(chain_curr[AVG_DEPTH]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsum_reg <= '0;
            csum_reg <= '0;
        end
        else if (shift)
        begin
            vsum_reg <= vsum_next;
            csum_reg <= csum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            item2_reg.op   <= op1_reg;
            item2_reg.vsum <= vsum_next;
            item2_reg.csum <= csum_next;
        end
    end

    // stage 3: comparators, latches and output word
    bmh_result_t result;

    bmh_detect u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load3),
        .cfg    (cfg_reg),
        .item   (item2_reg),
        .result (result)
    );

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            m_axis_tdata <= {2'b00, result.any_error, result.min_battery_error,
                             result.overcurrent_error, result.overvolt_error,
                             result.battery_low, result.on_external,
                             result.avg_current, result.avg_voltage};
        end
    end

`ifndef SYNTHESIS
    a_any_error_or: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[37] == (|m_axis_tdata[36:34]))
        else $error("any_error differs from the OR of the latches");

    a_low_not_external: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
        else $error("battery_low set while on external power");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted with a full pipeline");
`endif

endmodule
`default_nettype wire

@@ rtl/bmh_scale.sv @@
`default_nettype none
module bmh_scale
    import bmh_pkg::*;
(
    input  var bmh_cfg_t                 cfg,
    input  wire logic [CODE_W-1:0]       voltage_code,
    input  wire logic [CODE_W-1:0]       current_code,
    output logic [SAMPLE_W-1:0]          volt_scaled,
    output logic signed [SAMPLE_W-1:0]   curr_scaled
);

    logic [27:0]        vprod;
    logic [19:0]        vq;
    logic signed [12:0] cdiff;
    logic signed [29:0] cprod;
    logic signed [21:0] cq;

    assign vprod = 28'(voltage_code) * 28'(cfg.voltage_gain);
    assign vq    = vprod[27:8];

    always_comb
    begin
        if (|vq[19:16])
            volt_scaled = '1;
        else
            volt_scaled = vq[15:0];
    end

    assign cdiff = $signed({1'b0, current_code}) - $signed({1'b0, cfg.current_offset});
    assign cprod = 30'(cdiff) * $signed({13'b0, cfg.current_gain});
    // floor toward minus infinity, as an arithmetic shift does
    assign cq    = 22'(cprod >>> 8);

    always_comb
    begin
        if (cq > 22'sd32767)
            curr_scaled = 16'sh7FFF;
        else if (cq < -22'sd32768)
            curr_scaled = 16'sh8000;
        else
            curr_scaled = cq[15:0];
    end

endmodule
`default_nettype wire

@@ rtl/bmh_cell.sv @@
`default_nettype none
module bmh_cell
    import bmh_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift,
    input  wire logic [SAMPLE_W-1:0]         volt_in,
    input  wire logic signed [SAMPLE_W-1:0]  curr_in,
    output logic [SAMPLE_W-1:0]              volt_out,
    output logic signed [SAMPLE_W-1:0]       curr_out
);

    logic [SAMPLE_W-1:0]        volt_reg;
    logic signed [SAMPLE_W-1:0] curr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg <= '0;
            curr_reg <= '0;
        end
        else if (shift)
        begin
            volt_reg <= volt_in;
            curr_reg <= curr_in;
        end
    end

    assign volt_out = volt_reg;
    assign curr_out = curr_reg;

endmodule
`default_nettype wire

@@ rtl/bmh_detect.sv @@
`default_nettype none
module bmh_detect
    import bmh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  var bmh_cfg_t    cfg,
    input  var bmh_sum_item_t item,
    output bmh_result_t     result
);

    localparam int OV = 0;
    localparam int OC = 1;
    localparam int MB = 2;
    localparam int LB = 3;
    localparam int BP = 4;

    logic [4:0] flags_reg, flags_next;
    logic       ext_reg, ext_next;
    logic [2:0] latch_reg, latch_next;

    logic [SAMPLE_W-1:0]        avg_v;
    logic signed [SUM_W-1:0]    csum_adj;
    logic signed [SAMPLE_W-1:0] avg_c, cur_c;
    logic signed [CMP_W-1:0]    vv, cc;
    logic signed [CMP_W-1:0]    ov_hi, ov_lo, oc_hi, oc_lo;
    logic signed [CMP_W-1:0]    mb_lo, mb_hi, lb_lo, lb_hi, bp_lo, bp_hi;

    function automatic logic hyst(input logic flag, input logic signed [CMP_W-1:0] v,
                                  input logic signed [CMP_W-1:0] lo,
                                  input logic signed [CMP_W-1:0] hi);
        logic r;
        if (v > hi)
            r = 1'b1;
        else if (v < lo)
            r = 1'b0;
        else
            r = flag;
        return r;
    endfunction

    assign avg_v    = SAMPLE_W'(item.vsum >> AVG_SHIFT);
    // truncate toward zero: bias negative sums before the shift
    assign csum_adj = item.csum[SUM_W-1] ? item.csum + SUM_W'(AVG_DEPTH - 1) : item.csum;
    assign avg_c    = SAMPLE_W'(csum_adj >>> AVG_SHIFT);
    assign cur_c    = ext_reg ? '0 : avg_c;

    assign vv    = $signed({2'b00, avg_v});
    assign cc    = CMP_W'(cur_c);
    assign ov_hi = $signed({2'b00, cfg.overvolt_level});
    assign ov_lo = ov_hi - CMP_W'(VOLT_HYST);
    assign oc_hi = $signed({3'b000, cfg.overcurrent_level});
    assign oc_lo = oc_hi - CMP_W'(CURR_HYST);
    assign mb_lo = $signed({2'b00, cfg.min_battery_level});
    assign mb_hi = mb_lo + CMP_W'(VOLT_HYST);
    assign lb_lo = $signed({2'b00, cfg.low_battery_level});
    assign lb_hi = lb_lo + CMP_W'(VOLT_HYST);
    assign bp_lo = $signed({2'b00, cfg.battery_present_level});
    assign bp_hi = bp_lo + CMP_W'(VOLT_HYST);

    always_comb
    begin
        flags_next = flags_reg;
        ext_next   = ext_reg;
        latch_next = '0;
        if (item.op == OP_SAMPLE)
        begin
            flags_next[OV] = hyst(flags_reg[OV], vv, ov_lo, ov_hi);
            flags_next[OC] = hyst(flags_reg[OC], cc, oc_lo, oc_hi);
            flags_next[MB] = hyst(flags_reg[MB], vv, mb_lo, mb_hi);
            flags_next[LB] = hyst(flags_reg[LB], vv, lb_lo, lb_hi);
            flags_next[BP] = hyst(flags_reg[BP], vv, bp_lo, bp_hi);
            ext_next       = !flags_next[BP];
            latch_next     = latch_reg | {!flags_next[MB] && !ext_next,
                                          flags_next[OC], flags_next[OV]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            ext_reg   <= 1'b0;
            latch_reg <= '0;
        end
        else if (load)
        begin
            flags_reg <= flags_next;
            ext_reg   <= ext_next;
            latch_reg <= latch_next;
        end
    end

    always_comb
    begin
        result.avg_voltage       = avg_v;
        result.avg_current       = cur_c;
        result.on_external       = ext_next;
        result.battery_low       = !flags_next[LB] && !ext_next;
        result.overvolt_error    = latch_next[0];
        result.overcurrent_error = latch_next[1];
        result.min_battery_error = latch_next[2];
        result.any_error         = |latch_next;
    end

`ifndef SYNTHESIS
    a_clear_drops_latches: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.op == OP_CLEAR |=> latch_reg == '0)
        else $error("error latches not cleared by clear word");

    a_latches_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.op == OP_SAMPLE |=> (latch_reg & $past(latch_reg)) == $past(latch_reg))
        else $error("error latch dropped by a sample word");

    a_clear_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.op == OP_CLEAR |=> flags_reg == $past(flags_reg) && ext_reg == $past(ext_reg))
        else $error("comparator state moved on a clear word");
`endif

endmodule
`default_nettype wire

@@ dv/battery_monitor_hysteresis_test.sv @@
`default_nettype none
module battery_monitor_hysteresis_test;
    import bmh_pkg::*;

    localparam int CFG_REG_COUNT = 8;
    localparam int CMP_OVERVOLT  = 0;
    localparam int CMP_OVERCURR  = 1;
    localparam int CMP_MINBATT   = 2;
    localparam int CMP_LOWBATT   = 3;
    localparam int CMP_PRESENT   = 4;
    localparam int ERR_OVERVOLT  = 0;
    localparam int ERR_OVERCURR  = 1;
    localparam int ERR_MINBATT   = 2;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 175;
    localparam int WALK_STEP     = 300;
    localparam int CODE_MAX      = (1 << CODE_W) - 1;

    typedef struct {
        op_t         op;
        logic [11:0] vcode;
        logic [11:0] ccode;
    } sample_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    sample_word_t sample_q[$];
    bmh_result_t  readout_q[$];
    int           send_idle_pct = 33;
    int           recv_idle_pct = 65;
    int           n_fail = 0;
    int           quiet_cycles = 0;

    // predictor state, mirrors the block after reset
    bmh_cfg_t cfg_shadow = '{voltage_gain: 16'd256, current_offset: 12'd2048,
                             current_gain: 16'd256, min_battery_level: 16'd3300,
                             low_battery_level: 16'd3500, battery_present_level: 16'd1000,
                             overvolt_level: 16'd4300, overcurrent_level: 15'd10000};
    int         vwin[AVG_DEPTH] = '{default: 0};
    int         cwin[AVG_DEPTH] = '{default: 0};
    int         vsum = 0;
    int         csum = 0;
    int         slot = 0;
    logic [4:0] cmp_flags = '0;
    logic       ext_flag = 1'b0;
    logic [2:0] err_latch = '0;

    battery_monitor_hysteresis DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic schmitt(logic cur, int value, int lo, int hi);
        if (value > hi)
            return 1'b1;
        if (value < lo)
            return 1'b0;
        return cur;
    endfunction

    function automatic bmh_result_t predict_readout(sample_word_t w);
        bmh_result_t r;
        int prod;
        int sv;
        int sc;
        int avg_v;
        int avg_c;
        if (w.op == OP_CLEAR)
        begin
            err_latch = '0;
            avg_v = vsum / AVG_DEPTH;
            avg_c = ext_flag ? 0 : csum / AVG_DEPTH;
        end
        else
        begin
            prod = int'(w.vcode) * int'(cfg_shadow.voltage_gain);
            sv = prod >> 8;
            if (sv > 65535)
                sv = 65535;
            prod = (int'(w.ccode) - int'(cfg_shadow.current_offset))
                   * int'(cfg_shadow.current_gain);
            sc = prod >>> 8;
            if (sc > 32767)
                sc = 32767;
            if (sc < -32768)
                sc = -32768;
            vsum += sv - vwin[slot];
            csum += sc - cwin[slot];
            vwin[slot] = sv;
            cwin[slot] = sc;
            slot = (slot + 1) % AVG_DEPTH;
            avg_v = vsum / AVG_DEPTH;
            // gate with the flag left by the previous word
            avg_c = ext_flag ? 0 : csum / AVG_DEPTH;
            cmp_flags[CMP_OVERVOLT] = schmitt(cmp_flags[CMP_OVERVOLT], avg_v,
                int'(cfg_shadow.overvolt_level) - VOLT_HYST, int'(cfg_shadow.overvolt_level));
            cmp_flags[CMP_OVERCURR] = schmitt(cmp_flags[CMP_OVERCURR], avg_c,
                int'(cfg_shadow.overcurrent_level) - CURR_HYST,
                int'(cfg_shadow.overcurrent_level));
            cmp_flags[CMP_MINBATT] = schmitt(cmp_flags[CMP_MINBATT], avg_v,
                int'(cfg_shadow.min_battery_level),
                int'(cfg_shadow.min_battery_level) + VOLT_HYST);
            cmp_flags[CMP_LOWBATT] = schmitt(cmp_flags[CMP_LOWBATT], avg_v,
                int'(cfg_shadow.low_battery_level),
                int'(cfg_shadow.low_battery_level) + VOLT_HYST);
            cmp_flags[CMP_PRESENT] = schmitt(cmp_flags[CMP_PRESENT], avg_v,
                int'(cfg_shadow.battery_present_level),
                int'(cfg_shadow.battery_present_level) + VOLT_HYST);
            ext_flag = !cmp_flags[CMP_PRESENT];
            if (cmp_flags[CMP_OVERVOLT])
                err_latch[ERR_OVERVOLT] = 1'b1;
            if (cmp_flags[CMP_OVERCURR])
                err_latch[ERR_OVERCURR] = 1'b1;
            if (!cmp_flags[CMP_MINBATT] && !ext_flag)
                err_latch[ERR_MINBATT] = 1'b1;
        end
        r.avg_voltage       = avg_v[15:0];
        r.avg_current       = avg_c[15:0];
        r.on_external       = ext_flag;
        r.battery_low       = !cmp_flags[CMP_LOWBATT] && !ext_flag;
        r.overvolt_error    = err_latch[ERR_OVERVOLT];
        r.overcurrent_error = err_latch[ERR_OVERCURR];
        r.min_battery_error = err_latch[ERR_MINBATT];
        r.any_error         = |err_latch;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want !== got)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // sample driver, predicts each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        sample_word_t w;
        sample_word_t acc;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                acc.op    = op_t'(s_axis_tuser);
                acc.vcode = s_axis_tdata[11:0];
                acc.ccode = s_axis_tdata[23:12];
                readout_q.push_back(predict_readout(acc));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = sample_q.pop_front();
                    s_axis_tuser  <= w.op;
                    s_axis_tdata  <= {w.ccode, w.vcode};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        bmh_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (readout_q.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: result word with nothing expected, expected none, got %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = readout_q.pop_front();
                    check_field("avg_voltage", want.avg_voltage, m_axis_tdata[15:0]);
                    check_field("avg_current", want.avg_current, $signed(m_axis_tdata[31:16]));
                    check_field("on_external", want.on_external, m_axis_tdata[32]);
                    check_field("battery_low", want.battery_low, m_axis_tdata[33]);
                    check_field("overvolt_error", want.overvolt_error, m_axis_tdata[34]);
                    check_field("overcurrent_error", want.overcurrent_error, m_axis_tdata[35]);
                    check_field("min_battery_error", want.min_battery_error, m_axis_tdata[36]);
                    check_field("any_error", want.any_error, m_axis_tdata[37]);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("** battery_monitor_hysteresis: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_VOLTAGE_GAIN:    cfg_shadow.voltage_gain          = value;
            CFG_CURRENT_OFFSET:  cfg_shadow.current_offset        = value[11:0];
            CFG_CURRENT_GAIN:    cfg_shadow.current_gain          = value;
            CFG_MIN_BATTERY:     cfg_shadow.min_battery_level     = value;
            CFG_LOW_BATTERY:     cfg_shadow.low_battery_level     = value;
            CFG_BATTERY_PRESENT: cfg_shadow.battery_present_level = value;
            CFG_OVERVOLT:        cfg_shadow.overvolt_level        = value;
            CFG_OVERCURRENT:     cfg_shadow.overcurrent_level     = value[14:0];
            default: ;
        endcase
    endtask

    task automatic queue_sample(op_t op, int vcode, int ccode);
        sample_word_t w;
        w.op    = op;
        w.vcode = vcode[11:0];
        w.ccode = ccode[11:0];
        sample_q.push_back(w);
    endtask

    // hold until every word is sent and answered, then let the pipeline empty
    task automatic settle();
        while (sample_q.size() != 0 || s_axis_tvalid || readout_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int vgain;
        int cgain;
        int vmax;
        int cmax;
        int minlvl;
        int v_walk;
        int c_walk;
        int roll;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: gains raised so overvolt and overcurrent can trip
        write_reg(CFG_VOLTAGE_GAIN, 16'd300);
        write_reg(CFG_CURRENT_GAIN, 16'd2000);
        queue_sample(OP_CLEAR, 0, 0);
        repeat (8) queue_sample(OP_SAMPLE, CODE_MAX, CODE_MAX);
        queue_sample(OP_CLEAR, CODE_MAX, CODE_MAX);
        queue_sample(OP_SAMPLE, CODE_MAX, CODE_MAX);
        repeat (8) queue_sample(OP_SAMPLE, 0, 0);
        queue_sample(OP_SAMPLE, 0, 2048);
        queue_sample(OP_CLEAR, 0, 0);
        queue_sample(OP_SAMPLE, 12'hAAA, 12'h555);
        queue_sample(OP_SAMPLE, 12'h555, 12'hAAA);
        settle();

        v_walk = 0;
        c_walk = 2048;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 65;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase == 1)
            begin
                // bottom corner
                write_reg(CFG_VOLTAGE_GAIN, 16'd0);
                write_reg(CFG_CURRENT_OFFSET, 16'hF000 | 16'd4095);
                write_reg(CFG_CURRENT_GAIN, 16'hFFFF);
                write_reg(CFG_MIN_BATTERY, 16'd0);
                write_reg(CFG_LOW_BATTERY, 16'd0);
                write_reg(CFG_BATTERY_PRESENT, 16'd0);
                write_reg(CFG_OVERVOLT, 16'd0);
                write_reg(CFG_OVERCURRENT, 16'd0);
            end
            else if (phase == 2)
            begin
                // top corner, everything saturates
                write_reg(CFG_VOLTAGE_GAIN, 16'hFFFF);
                write_reg(CFG_CURRENT_OFFSET, 16'd0);
                write_reg(CFG_CURRENT_GAIN, 16'hFFFF);
                write_reg(CFG_MIN_BATTERY, 16'hFFFF);
                write_reg(CFG_LOW_BATTERY, 16'hFFFF);
                write_reg(CFG_BATTERY_PRESENT, 16'hFFFF);
                write_reg(CFG_OVERVOLT, 16'hFFFF);
                write_reg(CFG_OVERCURRENT, 16'hFFFF);
            end
            else
            begin
                // place the voltage levels inside the reachable range
                vgain = $urandom_range(128, 1024);
                vmax = (CODE_MAX * vgain) >> 8;
                if (vmax > 65535)
                    vmax = 65535;
                cgain = $urandom_range(64, 4096);
                cmax = (2048 * cgain) >> 8;
                if (cmax > 32767)
                    cmax = 32767;
                minlvl = $urandom_range(vmax / 4, vmax / 2);
                write_reg(CFG_VOLTAGE_GAIN, vgain[15:0]);
                write_reg(CFG_CURRENT_OFFSET,
                          {4'($urandom), 12'($urandom_range(1024, 3072))});
                write_reg(CFG_CURRENT_GAIN, cgain[15:0]);
                write_reg(CFG_MIN_BATTERY, minlvl[15:0]);
                write_reg(CFG_LOW_BATTERY, 16'(minlvl + $urandom_range(0, 600)));
                write_reg(CFG_BATTERY_PRESENT, 16'($urandom_range(0, vmax / 4)));
                write_reg(CFG_OVERVOLT, 16'($urandom_range(vmax / 2, vmax)));
                write_reg(CFG_OVERCURRENT, {1'($urandom), 15'($urandom_range(0, cmax))});
            end
            // indexes past the register list must be dropped
            write_reg(4'($urandom_range(CFG_REG_COUNT, 15)), 16'($urandom));

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 6)
                begin
                    queue_sample(OP_CLEAR, $urandom_range(0, CODE_MAX),
                                 $urandom_range(0, CODE_MAX));
                end
                else if (roll < 16)
                begin
                    queue_sample(OP_SAMPLE, $urandom_range(0, CODE_MAX),
                                 $urandom_range(0, CODE_MAX));
                end
                else
                begin
                    // slow drift so the averages sweep across the thresholds
                    if ($urandom_range(99) < 5)
                        v_walk = $urandom_range(0, CODE_MAX);
                    v_walk += $urandom_range(0, 2 * WALK_STEP) - WALK_STEP;
                    c_walk += $urandom_range(0, 2 * WALK_STEP) - WALK_STEP;
                    if (v_walk < 0)
                        v_walk = 0;
                    if (v_walk > CODE_MAX)
                        v_walk = CODE_MAX;
                    if (c_walk < 0)
                        c_walk = 0;
                    if (c_walk > CODE_MAX)
                        c_walk = CODE_MAX;
                    queue_sample(OP_SAMPLE, v_walk, c_walk);
                end
            end
            settle();
        end

        if (readout_q.size() != 0)
        begin
            n_fail++;
            $display("%0t: results missing, expected %0d more, got 0",
                     $time, readout_q.size());
        end
        if (n_fail == 0)
            $display("** battery_monitor_hysteresis: PASSED **");
        else
            $display("** battery_monitor_hysteresis: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
